/* rtl/mcfd_pkg.sv */
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types and constants for the motor command frame decoder.
// ----------------------------------------------------------------------------
package mcfd_pkg;

   // Frame bytes
   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] SECOND_BYTE = 8'h01;
   localparam logic [7:0] TAIL_BYTE   = 8'hFE;

   // Payload layout: four big-endian 16-bit commands
   localparam int unsigned PAYLOAD_LEN = 8;
   localparam int unsigned NUM_MOTORS  = 4;
   localparam int unsigned CMD_W       = 16;
   localparam int unsigned COUNT_W     = $clog2(PAYLOAD_LEN);

   typedef logic [7:0] byte_type;
   typedef byte_type [PAYLOAD_LEN-1:0] payload_type;

   // Framer phases, one-hot
   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_SECOND  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_TAIL    = 4'b1000
   } phase_type;

   // Decoded result item
   typedef struct packed {
      logic [NUM_MOTORS-1:0]            reverse;
      logic [NUM_MOTORS-1:0][CMD_W-1:0] magnitude;
      logic                             first_is_zero;
   } result_type;

endpackage

/* rtl/mcfd_framer.sv */
// ----------------------------------------------------------------------------
// mcfd_framer
// Header/second-byte/payload/tail state machine with the payload byte store.
// ----------------------------------------------------------------------------
module mcfd_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_take,
   input  mcfd_pkg::byte_type    rx_byte,
   output logic                  frame_done,
   output mcfd_pkg::payload_type payload
);
   import mcfd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   payload_type          store_ff;
   logic                 store_we;

   // Next phase and payload index
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      store_we   = 1'b0;
      frame_done = 1'b0;
      if (byte_take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == HEADER_BYTE) phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               // a bad second byte drops back to hunting, not taken as header
               if (rx_byte == SECOND_BYTE) begin
                  phase_in = PH_PAYLOAD;
                  count_in = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               store_we = 1'b1;
               count_in = count_ff + 1'b1;
               if (count_ff == COUNT_W'(PAYLOAD_LEN - 1)) phase_in = PH_TAIL;
            end
            PH_TAIL: begin
               // junk bytes are ignored until the tail shows up
               if (rx_byte == TAIL_BYTE) begin
                  phase_in   = PH_HUNT;
                  frame_done = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Payload store, no reset
   always_ff @(posedge clock) begin
      if (store_we) store_ff[count_ff] <= rx_byte;
   end

   assign payload = store_ff;

endmodule

/* rtl/mcfd_split.sv */
// ----------------------------------------------------------------------------
// mcfd_split
// Splits the four stored commands into direction bit and magnitude.
// ----------------------------------------------------------------------------
module mcfd_split (
   input  mcfd_pkg::payload_type payload,
   output mcfd_pkg::result_type  result
);
   import mcfd_pkg::*;

   logic [NUM_MOTORS-1:0][CMD_W-1:0] raw;

   // Sign/magnitude per motor; the most negative code maps to 0x8000
   always_comb begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
         raw[k]              = {payload[2*k], payload[2*k+1]};
         result.reverse[k]   = raw[k][CMD_W-1];
         result.magnitude[k] = raw[k][CMD_W-1] ? (CMD_W'(0) - raw[k]) : raw[k];
      end
      result.first_is_zero = (raw[0] == '0);
   end

endmodule

/* rtl/mcfd_out_stage.sv */
// ----------------------------------------------------------------------------
// mcfd_out_stage
// Result register with one skid entry so input keeps flowing under stall.
// ----------------------------------------------------------------------------
module mcfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcfd_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output mcfd_pkg::result_type out_data
);
   import mcfd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff && !out_stall;

   // Queue control: the skid entry only fills when main is held
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

/* rtl/motor_command_frame_decoder.sv */
// ----------------------------------------------------------------------------
// motor_command_frame_decoder
// Byte-serial motor command frame decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received serial byte per item (req_rx_byte).
//   rsp_ channel: one decoded frame per item, four direction/magnitude pairs
//   plus first_is_zero, emitted only when a complete frame ends on its tail.
//   A frame is 0xFF, 0x01, eight payload bytes (four big-endian signed
//   16-bit commands), then 0xFE; bytes before the tail are skipped.
//   Throughput: one byte per cycle while req_stall is low. A tail byte's
//   result goes to the result register, or to the skid entry while that is held;
//   per byte, one pass of logic lies between the input and those registers.
//   When rsp_stall holds a result, a skid entry absorbs one more result;
//   req_stall rises only while that skid entry is occupied, so non-tail and
//   tail bytes keep flowing until two results are pending.
//   Reset clears the framer to hunting for a header and empties the result
//   queue; payload bytes are not cleared and are always rewritten before use.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_reverse_a,
   output logic [15:0]              rsp_magnitude_a,
   output logic                     rsp_reverse_b,
   output logic [15:0]              rsp_magnitude_b,
   output logic                     rsp_reverse_c,
   output logic [15:0]              rsp_magnitude_c,
   output logic                     rsp_reverse_d,
   output logic [15:0]              rsp_magnitude_d,
   output logic                     rsp_first_is_zero
);
   import mcfd_pkg::*;

   logic        byte_take;
   logic        frame_done;
   logic        queue_full;
   payload_type payload;
   result_type  result;
   result_type  out_data;

   assign req_stall = queue_full;
   assign byte_take = req_valid && !queue_full;

   // Frame state machine and payload bytes
   mcfd_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .rx_byte    (req_rx_byte),
      .frame_done (frame_done),
      .payload    (payload)
   );

   // Command conversion
   mcfd_split u_split (
      .payload (payload),
      .result  (result)
   );

   // Result register and skid
   mcfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_done),
      .push_data (result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_reverse_a     = out_data.reverse[0];
   assign rsp_magnitude_a   = out_data.magnitude[0];
   assign rsp_reverse_b     = out_data.reverse[1];
   assign rsp_magnitude_b   = out_data.magnitude[1];
   assign rsp_reverse_c     = out_data.reverse[2];
   assign rsp_magnitude_c   = out_data.magnitude[2];
   assign rsp_reverse_d     = out_data.reverse[3];
   assign rsp_magnitude_d   = out_data.magnitude[3];
   assign rsp_first_is_zero = out_data.first_is_zero;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the motor command frame decoder. Serial bytes go in from a queue
// with random gaps and results come out under random stalls. Every accepted
// byte runs through a frame tracker that predicts the decoded commands, and
// each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   import mcfd_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1950;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RESET_CYCLES = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reverse_a;
   logic [15:0] rsp_magnitude_a;
   logic        rsp_reverse_b;
   logic [15:0] rsp_magnitude_b;
   logic        rsp_reverse_c;
   logic [15:0] rsp_magnitude_c;
   logic        rsp_reverse_d;
   logic [15:0] rsp_magnitude_d;
   logic        rsp_first_is_zero;

   // Bytes waiting to be sent, decoded frames waiting to come out
   byte_type    pending_rx[$];
   result_type  expected_frames[$];

   // Frame tracker state
   phase_type   frame_phase;
   logic [2:0]  payload_index;
   payload_type payload_bytes;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left    = 0;
   int unsigned hold_left   = 0;
   bit          send_busy   = 1'b1;
   bit          recv_busy   = 1'b1;
   string       motor_tag[NUM_MOTORS] = '{"a", "b", "c", "d"};

   motor_command_frame_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reverse_a    (rsp_reverse_a),
      .rsp_magnitude_a  (rsp_magnitude_a),
      .rsp_reverse_b    (rsp_reverse_b),
      .rsp_magnitude_b  (rsp_magnitude_b),
      .rsp_reverse_c    (rsp_reverse_c),
      .rsp_magnitude_c  (rsp_magnitude_c),
      .rsp_reverse_d    (rsp_reverse_d),
      .rsp_magnitude_d  (rsp_magnitude_d),
      .rsp_first_is_zero(rsp_first_is_zero)
   );

   always #1 clock = ~clock;

   // Wait length for one item; zero while a side runs flat out
   function automatic int unsigned draw_wait(bit busy);
      return busy ? $urandom_range(0, 7) : 0;
   endfunction

   // Track the frame through one accepted byte, queue a decoded frame on the tail
   task automatic decode_rx(input byte_type rx);
      result_type  want;
      logic [15:0] raw;
      case (frame_phase)
         PH_HUNT: begin
            if (rx == HEADER_BYTE) frame_phase = PH_SECOND;
         end
         PH_SECOND: begin
            // a bad second byte is never taken as a new header
            if (rx == SECOND_BYTE) begin
               frame_phase   = PH_PAYLOAD;
               payload_index = '0;
            end else begin
               frame_phase = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            payload_bytes[payload_index] = rx;
            if (payload_index == 3'(PAYLOAD_LEN - 1)) frame_phase = PH_TAIL;
            payload_index = payload_index + 3'd1;
         end
         default: begin
            // junk before the tail is dropped
            if (rx == TAIL_BYTE) begin
               frame_phase = PH_HUNT;
               for (int m = 0; m < NUM_MOTORS; m++) begin
                  raw = {payload_bytes[2*m], payload_bytes[2*m+1]};
                  want.reverse[m]   = raw[15];
                  want.magnitude[m] = raw[15] ? (~raw + 16'd1) : raw;
               end
               want.first_is_zero = ({payload_bytes[0], payload_bytes[1]} == 16'h0000);
               expected_frames.push_back(want);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compare one result with the oldest decoded frame
   task automatic check_frame();
      result_type want;
      result_type got;
      got.reverse       = {rsp_reverse_d, rsp_reverse_c, rsp_reverse_b, rsp_reverse_a};
      got.magnitude     = {rsp_magnitude_d, rsp_magnitude_c, rsp_magnitude_b,
                           rsp_magnitude_a};
      got.first_is_zero = rsp_first_is_zero;
      if (expected_frames.size() == 0) begin
         $error("result with no frame pending");
         error_count++;
      end else begin
         want = expected_frames.pop_front();
         for (int m = 0; m < NUM_MOTORS; m++) begin
            check_field({"reverse_", motor_tag[m]}, want.reverse[m], got.reverse[m]);
            check_field({"magnitude_", motor_tag[m]}, want.magnitude[m],
                        got.magnitude[m]);
         end
         check_field("first_is_zero", want.first_is_zero, got.first_is_zero);
      end
   endtask

   // Driver: presents queued bytes, feeds accepted ones to the tracker
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         gap_left      = 0;
         frame_phase   = PH_HUNT;
         payload_index = '0;
         payload_bytes = '0;
      end else begin
         if (req_valid && !req_stall) decode_rx(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_rx.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_rx.pop_front();
               if ($urandom_range(0, 63) == 0) send_busy = !send_busy;
               gap_left = draw_wait(send_busy);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result, then holds stall for a drawn time
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_frame();
            if ($urandom_range(0, 63) == 0) recv_busy = !recv_busy;
            hold_left = draw_wait(recv_busy);
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Pick a command, leaning on zero and the range edges
   function automatic logic [15:0] pick_command();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'h8000;
         2:       return 16'h7FFF;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_frame(input int unsigned junk_count);
      logic [15:0] cmd;
      byte_type    junk;
      pending_rx.push_back(HEADER_BYTE);
      pending_rx.push_back(SECOND_BYTE);
      for (int m = 0; m < NUM_MOTORS; m++) begin
         cmd = pick_command();
         pending_rx.push_back(cmd[15:8]);
         pending_rx.push_back(cmd[7:0]);
      end
      for (int j = 0; j < junk_count; j++) begin
         do junk = 8'($urandom); while (junk == TAIL_BYTE);
         pending_rx.push_back(junk);
      end
      pending_rx.push_back(TAIL_BYTE);
   endtask

   initial begin
      byte_type    directed[] = '{
         // tail while hunting, bad second byte 0xFF, stray 0x01 while hunting
         8'hFE, 8'hFF, 8'hFF, 8'h01,
         // bad second byte other than 0xFF
         8'hFF, 8'h02,
         // A = 0 (acknowledge), B = most negative, C = most positive, D = -1,
         // one junk byte before the tail
         8'hFF, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
         8'h37, 8'hFE
      };
      int unsigned queued;
      int unsigned kind;
      int unsigned before_size;
      byte_type    bad;

      foreach (directed[i]) pending_rx.push_back(directed[i]);
      queued = directed.size();

      // Mostly clean frames, some with junk before the tail, some broken starts,
      // and a little noise
      while (queued < ITEM_TARGET) begin
         kind        = $urandom_range(0, 19);
         before_size = pending_rx.size();
         if (kind < 15) begin
            queue_frame(kind < 3 ? $urandom_range(1, 3) : 0);
            queued += pending_rx.size() - before_size;
         end else if (kind < 17) begin
            do bad = 8'($urandom); while (bad == SECOND_BYTE);
            pending_rx.push_back(HEADER_BYTE);
            pending_rx.push_back(bad);
            queued += 2;
         end else begin
            repeat ($urandom_range(1, 4)) pending_rx.push_back(8'($urandom));
            queued += pending_rx.size() - before_size;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Let everything drain
      while (pending_rx.size() != 0 || req_valid) @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
